### design/rans_byte_encoder_assert.svh
// Assertion macros shared by the rANS byte encoder RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef RANS_BYTE_ENCODER_ASSERT_SVH
`define RANS_BYTE_ENCODER_ASSERT_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define RBE_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle.
`define RBE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### design/rbe_pkg.sv
// Package for the rANS byte encoder: widths, request codes, table entry type.
// Depends on nothing.
package rbe_pkg;
    localparam int SYMBOLS   = 256;
    localparam int SYM_W     = 8;
    localparam int FREQ_BITS = 16;
    localparam int OUT_BITS  = 8;
    localparam int STATE_W   = 32;
    localparam int QUOT_CNT_W = 6;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_INIT  = 1'b1;

    typedef struct packed {
        logic [FREQ_BITS-1:0] freq;
        logic [FREQ_BITS-1:0] cum;
        logic [STATE_W-1:0]   max_state;
    } entry_t;

    typedef struct packed {
        logic                 start;
        logic [STATE_W-1:0]   dividend;
        logic [FREQ_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [STATE_W-1:0]   quot;
        logic [FREQ_BITS-1:0] rem;
    } div_rsp_t;
endpackage

### design/rbe_table.sv
// Symbol table memory of the rANS encoder: one write port, one registered read.
// Depends on rbe_pkg.
module rbe_table
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [rbe_pkg::SYM_W-1:0] wr_addr,
    input  rbe_pkg::entry_t           wr_data,
    input  logic [rbe_pkg::SYM_W-1:0] rd_addr,
    output rbe_pkg::entry_t           rd_data
);
    rbe_pkg::entry_t mem [rbe_pkg::SYMBOLS];

    // Write and read the entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### design/rbe_divider.sv
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
// Depends on rbe_pkg.
module rbe_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rbe_pkg::div_req_t req,
    output rbe_pkg::div_rsp_t rsp
);
    logic                                busy_reg;
    logic [rbe_pkg::QUOT_CNT_W-1:0]      cnt_reg;
    logic [rbe_pkg::STATE_W-1:0]         quot_reg;
    logic [rbe_pkg::FREQ_BITS:0]         rem_reg;
    logic [rbe_pkg::FREQ_BITS-1:0]       dvs_reg;
    logic                                done_reg;
    logic [rbe_pkg::FREQ_BITS:0]         trial;
    logic                                fits;

    // Shift one dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        trial = {rem_reg[rbe_pkg::FREQ_BITS-1:0], quot_reg[rbe_pkg::STATE_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    // Start on a request, then advance one quotient bit per cycle while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quot_reg <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                quot_reg <= {quot_reg[rbe_pkg::STATE_W-2:0], fits};
                rem_reg  <= fits ? trial - {1'b0, dvs_reg} : trial;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == rbe_pkg::QUOT_CNT_W'(rbe_pkg::STATE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg[rbe_pkg::FREQ_BITS-1:0];
endmodule

### design/rans_byte_encoder.sv
// rANS byte encoder. Requests are taken one at a time: a load writes a table
// entry, a finish emits the four state bytes plus output stalls, an encode
// emits up to four shrink bytes, divides and multiplies, plus output stalls
// (one error byte for a zero-frequency symbol). The encode time is set by the
// bit-serial divider that forms state / freq and state % freq. The symbol
// table is a 256-entry memory with a registered read; entries must be loaded
// before use. Results leave through an output register, stalled by out_stall.
// Depends on rbe_pkg, rbe_table, rbe_divider and rans_byte_encoder_assert.svh.
`include "rans_byte_encoder_assert.svh"
module rans_byte_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  symbol,
    input  logic [15:0] entry_freq,
    input  logic [15:0] entry_cum_freq,
    input  logic [31:0] entry_max_state,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_state_byte,
    output logic        error,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_SHRINK, ST_DIV, ST_MUL, ST_FLUSH, ST_DRAIN
    } state_t;

    state_t                       state_reg;
    logic [15:0]                  total_reg;
    logic [31:0]                  init_reg;
    logic [31:0]                  coder_reg;
    logic [2:0]                   cnt_reg;
    logic [31:0]                  prod_reg;
    logic [7:0]                   sym_reg;
    logic [7:0]                   out_byte_reg;
    logic                         is_state_reg;
    logic                         error_reg;
    logic                         last_reg;
    logic                         out_valid_reg;
    rbe_pkg::entry_t              ent;
    rbe_pkg::entry_t              wr_ent;
    rbe_pkg::div_req_t            dreq;
    rbe_pkg::div_rsp_t            drsp;
    logic                         accept;
    logic                         out_free;
    logic                         more;
    logic                         out_load;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || !out_stall;
    assign more     = coder_reg > ent.max_state && cnt_reg != 3'd4;

    // Load the output register this cycle
    assign out_load = out_free
                      && ((state_reg == ST_SHRINK && (ent.freq == '0 || more))
                          || state_reg == ST_FLUSH);

    assign wr_ent.freq      = entry_freq;
    assign wr_ent.cum       = entry_cum_freq;
    assign wr_ent.max_state = entry_max_state;

    rbe_table u_table
    (
        .clk     (clk),
        .wr_en   (accept && req_type == rbe_pkg::REQ_LOAD),
        .wr_addr (symbol),
        .wr_data (wr_ent),
        .rd_addr (accept ? symbol : sym_reg),
        .rd_data (ent)
    );

    assign dreq.start    = state_reg == ST_SHRINK && out_free && !more
                           && ent.freq != '0;
    assign dreq.dividend = coder_reg;
    assign dreq.divisor  = ent.freq;

    rbe_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Sequence requests, take config writes, hold coder state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= 16'd1;
            init_reg      <= '0;
            coder_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            prod_reg      <= '0;
            sym_reg       <= '0;
            out_byte_reg  <= '0;
            is_state_reg  <= 1'b0;
            error_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rbe_pkg::CFG_TOTAL)
                    total_reg <= cfg_data[15:0];
                else
                    init_reg <= cfg_data;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sym_reg <= symbol;
                        cnt_reg <= '0;
                        case (req_type)
                            rbe_pkg::REQ_ENCODE: state_reg <= ST_READ;
                            rbe_pkg::REQ_FINISH: state_reg <= ST_FLUSH;
                            default:             state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_READ:
                    state_reg <= ST_SHRINK;
                ST_SHRINK:
                begin
                    if (out_free)
                    begin
                        if (ent.freq == '0)
                        begin
                            out_byte_reg  <= '0;
                            is_state_reg  <= 1'b0;
                            error_reg     <= 1'b1;
                            last_reg      <= 1'b1;
                            state_reg     <= ST_DRAIN;
                        end
                        else if (more)
                        begin
                            out_byte_reg  <= coder_reg[7:0];
                            is_state_reg  <= 1'b0;
                            error_reg     <= 1'b0;
                            last_reg      <= !({8'd0, coder_reg[31:8]} > ent.max_state
                                               && cnt_reg != 3'd3);
                            coder_reg     <= {8'd0, coder_reg[31:8]};
                            cnt_reg       <= cnt_reg + 1'b1;
                        end
                        else
                            state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (drsp.done)
                    begin
                        prod_reg  <= drsp.quot * {16'd0, total_reg};
                        coder_reg <= {16'd0, drsp.rem} + {16'd0, ent.cum};
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    coder_reg <= coder_reg + prod_reg;
                    state_reg <= ST_DRAIN;
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_byte_reg  <= coder_reg[31:24];
                        is_state_reg  <= 1'b1;
                        error_reg     <= 1'b0;
                        last_reg      <= cnt_reg == 3'd3;
                        coder_reg     <= (cnt_reg == 3'd3) ? init_reg
                                                           : {coder_reg[23:0], 8'd0};
                        cnt_reg       <= cnt_reg + 1'b1;
                        if (cnt_reg == 3'd3)
                            state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                    state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_state_byte = is_state_reg;
    assign error         = error_reg;
    assign last          = last_reg;

    `RBE_ASSERT_IMPLY(a_busy_stall, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `RBE_ASSERT_NEXT(a_div_done, clk, rst_n, dreq.start, state_reg == ST_DIV)
    `RBE_ASSERT_IMPLY(a_err_last, clk, rst_n, out_valid && error, last && !is_state_byte)
endmodule
